// File: src/knn_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the three-nearest-neighbour classifier; no dependencies
package knn_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int NEIGHBOURS_DEF = 3;

   localparam int OP_W    = 2;
   localparam int TEMP_W  = 11;
   localparam int RAIN_W  = 14;
   localparam int LABEL_W = 3;
   localparam int CODE_W  = 3;
   localparam int DIST_W  = 30;
   localparam int TSQ_W   = 22;
   localparam int RSQ_W   = 28;
   localparam int POINT_W = 3 * TEMP_W + RAIN_W + LABEL_W;

   localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
   localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   localparam logic [CODE_W-1:0]  CODE_UNIDENTIFIED = 3'd5;
   localparam logic [LABEL_W-1:0] LABEL_MAX         = 3'd4;
   localparam logic [DIST_W-1:0]  DIST_MAX          = {DIST_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VOTE
   } state_type;

   typedef struct packed {
      logic write;
      logic respond_full;
      logic clear;
      logic capture;
      logic issue;
      logic respond_vote;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic pipe_busy;
   } status_type;

endpackage

// File: src/knn_unanimous_classifier.sv
// classify: one stored point per cycle through the store read port and a three-stage
// distance pipeline; busy meanwhile
// load, clear: a new word may follow at once; a rejected load strobes its result in the
// next cycle. results are strobed and cannot be stalled
// synchronous reset empties the store; point contents stay undefined until loaded
// top level: joins knn_ctrl and knn_datapath, depends on knn_pkg
module knn_unanimous_classifier #(
   parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
   parameter int NEIGHBOURS = knn_pkg::NEIGHBOURS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [knn_pkg::OP_W-1:0]           req_operation,
   input  logic signed [knn_pkg::TEMP_W-1:0]  req_mean_temp,
   input  logic signed [knn_pkg::TEMP_W-1:0]  req_low_temp,
   input  logic signed [knn_pkg::TEMP_W-1:0]  req_high_temp,
   input  logic [knn_pkg::RAIN_W-1:0]         req_rainfall,
   input  logic [knn_pkg::LABEL_W-1:0]        req_class_label,
   output logic                               rsp_valid,
   output logic [knn_pkg::CODE_W-1:0]         rsp_class_code,
   output logic                               rsp_store_full
);

   knn_pkg::cmd_type    cmd;
   knn_pkg::status_type status;

   knn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .operation(req_operation),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   knn_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .NEIGHBOURS(NEIGHBOURS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .mean_temp     (req_mean_temp),
      .low_temp      (req_low_temp),
      .high_temp     (req_high_temp),
      .rainfall      (req_rainfall),
      .class_label   (req_class_label),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_class_code(rsp_class_code),
      .rsp_store_full(rsp_store_full)
   );

endmodule

// File: src/knn_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module knn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/knn_ctrl.sv
// controller state machine: decodes commands, sequences the scan and vote
// depends on knn_pkg
module knn_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [knn_pkg::OP_W-1:0]    operation,
   input  knn_pkg::status_type         status,
   output logic                        busy,
   output knn_pkg::cmd_type            cmd
);

   knn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         knn_pkg::ST_IDLE: begin
            if (start && operation == knn_pkg::OP_CLASSIFY) begin
               state_in = knn_pkg::ST_SCAN;
            end
         end
         knn_pkg::ST_SCAN: begin
            if (status.scan_done && !status.pipe_busy) begin
               state_in = knn_pkg::ST_VOTE;
            end
         end
         knn_pkg::ST_VOTE: state_in = knn_pkg::ST_IDLE;
         default: state_in = knn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         knn_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (operation)
                  knn_pkg::OP_LOAD: begin
                     cmd.write        = !status.full;
                     cmd.respond_full = status.full;
                  end
                  knn_pkg::OP_CLASSIFY: cmd.capture = 1'b1;
                  knn_pkg::OP_CLEAR: cmd.clear = 1'b1;
                  default: cmd = '0;
               endcase
            end
         end
         knn_pkg::ST_SCAN: cmd.issue = !status.scan_done;
         knn_pkg::ST_VOTE: cmd.respond_vote = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// File: src/knn_datapath.sv
// datapath: point store, distance pipeline, sorted best list and vote
// depends on knn_pkg and knn_ram
module knn_datapath #(
   parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
   parameter int NEIGHBOURS = knn_pkg::NEIGHBOURS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  knn_pkg::cmd_type                   cmd,
   input  logic signed [knn_pkg::TEMP_W-1:0]  mean_temp,
   input  logic signed [knn_pkg::TEMP_W-1:0]  low_temp,
   input  logic signed [knn_pkg::TEMP_W-1:0]  high_temp,
   input  logic [knn_pkg::RAIN_W-1:0]         rainfall,
   input  logic [knn_pkg::LABEL_W-1:0]        class_label,
   output knn_pkg::status_type                status,
   output logic                               rsp_valid,
   output logic [knn_pkg::CODE_W-1:0]         rsp_class_code,
   output logic                               rsp_store_full
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int TW = knn_pkg::TEMP_W;
   localparam int RW = knn_pkg::RAIN_W;
   localparam int LW = knn_pkg::LABEL_W;
   localparam int DW = knn_pkg::DIST_W;

   logic [CW-1:0] count_ff, idx_ff;
   logic signed [TW-1:0] q_mean_ff, q_low_ff, q_high_ff;
   logic [RW-1:0] q_rain_ff;
   logic [knn_pkg::POINT_W-1:0] wr_point, rd_point;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [TW-1:0] p_mean, p_low, p_high;
   logic [RW-1:0] p_rain;
   logic [LW-1:0] p_label;
   logic signed [TW:0] d_mean, d_low, d_high;
   logic signed [RW:0] d_rain;
   logic signed [2*TW+1:0] m_mean, m_low, m_high;
   logic signed [2*RW+1:0] m_rain;

   logic [knn_pkg::TSQ_W-1:0] sq_mean_ff, sq_low_ff, sq_high_ff;
   logic [knn_pkg::RSQ_W-1:0] sq_rain_ff;
   logic [LW-1:0] lab2_ff, lab3_ff;
   logic [DW-1:0] dist_ff;

   logic [DW-1:0] best_dist_ff [NEIGHBOURS];
   logic [LW-1:0] best_lab_ff [NEIGHBOURS];
   logic [NEIGHBOURS-1:0] closer;

   logic rsp_valid_ff, rsp_full_ff;
   logic [knn_pkg::CODE_W-1:0] rsp_code_ff;
   logic same;
   logic [knn_pkg::CODE_W-1:0] vote_code;

   assign wr_point = {mean_temp, low_temp, high_temp, rainfall, class_label};

   knn_ram #(
      .WIDTH(knn_pkg::POINT_W),
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.write),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(wr_point),
      .rd_en  (cmd.issue),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_point)
   );

   assign status.full      = (count_ff == CW'(MAX_POINTS));
   assign status.scan_done = (idx_ff == count_ff);
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.write) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= cmd.respond_full | cmd.respond_vote;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_mean_ff <= mean_temp;
         q_low_ff  <= low_temp;
         q_high_ff <= high_temp;
         q_rain_ff <= rainfall;
      end
   end

   // stage 1: differences and squares
   assign {p_mean, p_low, p_high, p_rain, p_label} = rd_point;
   assign d_mean = {q_mean_ff[TW-1], q_mean_ff} - {p_mean[TW-1], p_mean};
   assign d_low  = {q_low_ff[TW-1], q_low_ff} - {p_low[TW-1], p_low};
   assign d_high = {q_high_ff[TW-1], q_high_ff} - {p_high[TW-1], p_high};
   assign d_rain = $signed({1'b0, q_rain_ff}) - $signed({1'b0, p_rain});
   assign m_mean = d_mean * d_mean;
   assign m_low  = d_low * d_low;
   assign m_high = d_high * d_high;
   assign m_rain = d_rain * d_rain;

   always_ff @(posedge clock) begin
      sq_mean_ff <= m_mean[knn_pkg::TSQ_W-1:0];
      sq_low_ff  <= m_low[knn_pkg::TSQ_W-1:0];
      sq_high_ff <= m_high[knn_pkg::TSQ_W-1:0];
      sq_rain_ff <= m_rain[knn_pkg::RSQ_W-1:0];
      lab2_ff    <= p_label;
      dist_ff    <= DW'(sq_mean_ff) + DW'(sq_low_ff) + DW'(sq_high_ff) + DW'(sq_rain_ff);
      lab3_ff    <= lab2_ff;
   end

   // stage 3: sorted insert, ties keep the earlier point
   always_comb begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
         closer[k] = dist_ff < best_dist_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int k = 0; k < NEIGHBOURS; k++) begin
            best_dist_ff[k] <= knn_pkg::DIST_MAX;
            best_lab_ff[k]  <= '0;
         end
      end else if (v3_ff) begin
         for (int k = 0; k < NEIGHBOURS; k++) begin
            if (closer[k]) begin
               if (k == 0) begin
                  best_dist_ff[k] <= dist_ff;
                  best_lab_ff[k]  <= lab3_ff;
               end else if (!closer[k-1]) begin
                  best_dist_ff[k] <= dist_ff;
                  best_lab_ff[k]  <= lab3_ff;
               end else begin
                  best_dist_ff[k] <= best_dist_ff[k-1];
                  best_lab_ff[k]  <= best_lab_ff[k-1];
               end
            end
         end
      end
   end

   always_comb begin
      same = 1'b1;
      for (int k = 1; k < NEIGHBOURS; k++) begin
         if (best_lab_ff[k] != best_lab_ff[0]) begin
            same = 1'b0;
         end
      end
      vote_code = knn_pkg::CODE_UNIDENTIFIED;
      if (int'(count_ff) >= NEIGHBOURS && same && best_lab_ff[0] <= knn_pkg::LABEL_MAX) begin
         vote_code = best_lab_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond_full) begin
         rsp_code_ff <= knn_pkg::CODE_UNIDENTIFIED;
         rsp_full_ff <= 1'b1;
      end else if (cmd.respond_vote) begin
         rsp_code_ff <= vote_code;
         rsp_full_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_code = rsp_code_ff;
   assign rsp_store_full = rsp_full_ff;

endmodule

// File: tb/knn_unanimous_classifier_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for knn_unanimous_classifier: a clocked driver and monitor,
// with a built-in three-nearest-neighbour predictor checking every result word
// depends on knn_pkg and the knn_unanimous_classifier rtl
module knn_unanimous_classifier_tb;

   localparam int STORE_DEPTH = knn_pkg::MAX_POINTS_DEF;
   localparam int KEEP        = knn_pkg::NEIGHBOURS_DEF;
   localparam int IDLE_LIMIT  = 4000;
   localparam logic [knn_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [knn_pkg::OP_W-1:0]          op;
      logic signed [knn_pkg::TEMP_W-1:0] mean_t;
      logic signed [knn_pkg::TEMP_W-1:0] low_t;
      logic signed [knn_pkg::TEMP_W-1:0] high_t;
      logic [knn_pkg::RAIN_W-1:0]        rain;
      logic [knn_pkg::LABEL_W-1:0]       label;
   } climate_word_type;

   typedef struct {
      logic [knn_pkg::CODE_W-1:0] code;
      logic                       full;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [knn_pkg::OP_W-1:0]          req_operation   = knn_pkg::OP_LOAD;
   logic signed [knn_pkg::TEMP_W-1:0] req_mean_temp   = '0;
   logic signed [knn_pkg::TEMP_W-1:0] req_low_temp    = '0;
   logic signed [knn_pkg::TEMP_W-1:0] req_high_temp   = '0;
   logic [knn_pkg::RAIN_W-1:0]        req_rainfall    = '0;
   logic [knn_pkg::LABEL_W-1:0]       req_class_label = '0;
   logic                              rsp_valid;
   logic [knn_pkg::CODE_W-1:0]        rsp_class_code;
   logic                              rsp_store_full;

   climate_word_type pending_words[$];
   verdict_type      expected_verdicts[$];
   climate_word_type held_word;
   int               gap_left = 0;
   int               fail_count = 0;
   int               idle_cycles = 0;
   int               words_queued = 0;

   // predictor state
   climate_word_type ref_points[STORE_DEPTH];
   int               ref_count = 0;

   knn_unanimous_classifier dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_mean_temp(req_mean_temp),
      .req_low_temp(req_low_temp), .req_high_temp(req_high_temp),
      .req_rainfall(req_rainfall), .req_class_label(req_class_label),
      .rsp_valid(rsp_valid), .rsp_class_code(rsp_class_code),
      .rsp_store_full(rsp_store_full)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint sq(longint a, longint b);
      return (a - b) * (a - b);
   endfunction

   task automatic predict_word(input climate_word_type w);
      longint        best_dist[KEEP];
      logic [2:0]    best_lab[KEEP];
      longint        d;
      int            pos;
      logic          same;
      verdict_type   v;
      for (int k = 0; k < KEEP; k++) begin
         best_dist[k] = knn_pkg::DIST_MAX;
         best_lab[k] = '0;
      end
      case (w.op)
         knn_pkg::OP_LOAD: begin
            if (ref_count >= STORE_DEPTH) begin
               v.code = knn_pkg::CODE_UNIDENTIFIED;
               v.full = 1'b1;
               expected_verdicts.insert(expected_verdicts.size(), v);
            end else begin
               ref_points[ref_count] = w;
               ref_count++;
            end
         end
         knn_pkg::OP_CLEAR: ref_count = 0;
         knn_pkg::OP_CLASSIFY: begin
            for (int i = 0; i < ref_count; i++) begin
               d = sq(ref_points[i].mean_t, w.mean_t) + sq(ref_points[i].low_t, w.low_t)
                 + sq(ref_points[i].high_t, w.high_t)
                 + sq(longint'(ref_points[i].rain), longint'(w.rain));
               pos = 0;
               while (pos < KEEP && best_dist[pos] <= d) pos++;
               if (pos < KEEP) begin
                  for (int k = KEEP - 1; k > pos; k--) begin
                     best_dist[k] = best_dist[k-1];
                     best_lab[k] = best_lab[k-1];
                  end
                  best_dist[pos] = d;
                  best_lab[pos] = ref_points[i].label;
               end
            end
            v.code = knn_pkg::CODE_UNIDENTIFIED;
            v.full = 1'b0;
            if (ref_count >= KEEP) begin
               same = 1'b1;
               for (int k = 1; k < KEEP; k++)
                  if (best_lab[k] != best_lab[0]) same = 1'b0;
               if (same && best_lab[0] <= knn_pkg::LABEL_MAX) v.code = best_lab[0];
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
         end
         default: ;
      endcase
   endtask

   task automatic present(input climate_word_type w);
      req_operation   <= w.op;
      req_mean_temp   <= w.mean_t;
      req_low_temp    <= w.low_t;
      req_high_temp   <= w.high_t;
      req_rainfall    <= w.rain;
      req_class_label <= w.label;
      held_word = w;
   endtask

   // driver
   always @(posedge clock) begin
      int g;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_word(held_word);
         g = $urandom_range(0, 5);
         if (g == 0 && pending_words.size() > 0) begin
            present(pending_words.pop_front());
         end else begin
            start <= 1'b0;
            gap_left <= (g > 0) ? g - 1 : 0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_words.size() > 0) begin
            present(pending_words.pop_front());
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result word code=%0d full=%0d", rsp_class_code, rsp_store_full);
            fail_count++;
         end else begin
            v = expected_verdicts.pop_front();
            if (rsp_class_code !== v.code) begin
               $error("class_code expected %0d actual %0d", v.code, rsp_class_code);
               fail_count++;
            end
            if (rsp_store_full !== v.full) begin
               $error("store_full expected %0d actual %0d", v.full, rsp_store_full);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("knn_unanimous_classifier_tb: FAIL");
            $finish;
         end
      end
   end

   function automatic int clip(int x, int lo, int hi);
      return (x < lo) ? lo : (x > hi) ? hi : x;
   endfunction

   task automatic queue_word(input logic [1:0] op, input int m, input int l, input int h,
                             input int r, input int lab);
      climate_word_type w;
      w.op = op;
      w.mean_t = m;
      w.low_t = l;
      w.high_t = h;
      w.rain = r;
      w.label = lab;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // point near the cluster of a label, or anywhere when wild
   task automatic queue_near(input logic [1:0] op, input int lab, input bit wild);
      int cm;
      int cr;
      int sp;
      if (wild) begin
         queue_word(op, $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                    $urandom_range(0, 2000) - 1000, $urandom_range(0, 16383), lab);
      end else begin
         cm = -900 + (lab % 8) * 250;
         cr = (lab % 8) * 2200;
         sp = $urandom_range(5, 60);
         queue_word(op, clip(cm + $urandom_range(0, 2*sp) - sp, -1000, 1000),
                    clip(cm - 100 + $urandom_range(0, 2*sp) - sp, -1000, 1000),
                    clip(cm + 100 + $urandom_range(0, 2*sp) - sp, -1000, 1000),
                    clip(cr + $urandom_range(0, 8*sp) - 4*sp, 0, 16383), lab);
      end
   endtask

   initial begin
      int lab;
      int n;
      // directed: empty store, too few points, extremes, odd labels, unused op, clear
      queue_word(knn_pkg::OP_CLASSIFY, 0, 0, 0, 0, 0);
      queue_word(knn_pkg::OP_LOAD, -1000, -1000, -1000, 0, 0);
      queue_word(knn_pkg::OP_LOAD, 1000, 1000, 1000, 16383, 4);
      queue_word(knn_pkg::OP_CLASSIFY, 1000, 1000, 1000, 16383, 0);
      queue_word(knn_pkg::OP_LOAD, 1000, 1000, 1000, 16383, 4);
      queue_word(knn_pkg::OP_LOAD, 999, 1000, 1000, 16383, 4);
      queue_word(knn_pkg::OP_CLASSIFY, 1000, 1000, 1000, 16383, 7);
      queue_word(knn_pkg::OP_CLASSIFY, -1000, -1000, -1000, 0, 0);
      queue_word(OP_UNUSED, 500, -500, 1, 8191, 3);
      queue_word(knn_pkg::OP_CLEAR, -1, 1, 0, 1, 1);
      for (int i = 0; i < 3; i++) queue_word(knn_pkg::OP_LOAD, 10, 20, 30, 40, 6);
      queue_word(knn_pkg::OP_CLASSIFY, 10, 20, 30, 40, 0);
      queue_word(knn_pkg::OP_LOAD, 10, 20, 30, 40, 1);
      queue_word(knn_pkg::OP_CLASSIFY, 10, 20, 30, 40, 0);
      queue_word(knn_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) queue_word(knn_pkg::OP_LOAD, 0, 0, 0, 100, 2 + i);
      queue_word(knn_pkg::OP_CLASSIFY, 0, 0, 0, 100, 0);
      queue_word(knn_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      // fill the store past capacity
      for (int i = 0; i < STORE_DEPTH + 4; i++) begin
         lab = $urandom_range(0, 4);
         queue_near(knn_pkg::OP_LOAD, lab, $urandom_range(0, 9) == 0);
      end
      for (int i = 0; i < 3; i++) queue_near(knn_pkg::OP_CLASSIFY, $urandom_range(0, 4), 1'b0);
      // random sessions
      while (words_queued < 1750) begin
         if ($urandom_range(0, 3) != 0) queue_word(knn_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
         for (int i = 0; i < n; i++) begin
            lab = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            queue_near(knn_pkg::OP_LOAD, lab, $urandom_range(0, 7) == 0);
         end
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
               0: queue_word(OP_UNUSED, $urandom_range(0, 2000) - 1000, 0, 0,
                             $urandom_range(0, 16383), $urandom_range(0, 7));
               1, 2, 3: queue_near(knn_pkg::OP_CLASSIFY, $urandom_range(0, 7), 1'b1);
               default: queue_near(knn_pkg::OP_CLASSIFY, $urandom_range(0, 7), 1'b0);
            endcase
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && !start);
      wait (expected_verdicts.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_verdicts.size() == 0)
         $display("knn_unanimous_classifier_tb: PASS");
      else
         $display("knn_unanimous_classifier_tb: FAIL");
      $finish;
   end

endmodule
